/* rtl/core/dlri_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlri_pkg
// Shared types, constants and helpers for the DDA line rasterizer core.
// ----------------------------------------------------------------------------
package dlri_pkg;

   localparam int COORD_W      = 24;
   localparam int ACC_W        = 40;
   localparam int POS_W        = 16;
   localparam int SCR_W        = 13;
   localparam int DIVD_W       = 33;
   localparam int EXT_W        = 16;
   localparam int NUM_ACC      = 5;
   localparam int IDX_W        = 3;
   localparam int CNT_W        = 6;
   localparam int MUL_CNT_W    = 4;
   localparam int REQ_DATA_W   = 192;
   localparam int RSP_DATA_W   = 80;

   localparam logic [SCR_W-1:0] MAX_DIM        = 13'd4096;
   localparam logic [SCR_W-1:0] WIDTH_RESET    = 13'd1024;
   localparam logic [SCR_W-1:0] HEIGHT_RESET   = 13'd768;
   localparam logic [CNT_W-1:0] DIV_LAST_CNT   = 6'd32;
   localparam logic [IDX_W-1:0] LAST_ACC       = 3'd4;

   // Accumulator slots; the step deltas use the same order.
   localparam logic [IDX_W-1:0] ACC_MINOR = 3'd0;
   localparam logic [IDX_W-1:0] ACC_DEPTH = 3'd1;
   localparam logic [IDX_W-1:0] ACC_RED   = 3'd2;
   localparam logic [IDX_W-1:0] ACC_GREEN = 3'd3;
   localparam logic [IDX_W-1:0] ACC_BLUE  = 3'd4;

   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_DIV   = 4'b0010,
      ST_DIVWR = 4'b0100,
      ST_MUL   = 4'b1000
   } state_type;

   // Whole-pixel part of a coordinate, rounded toward zero.
   function automatic logic [POS_W-1:0] coord_trunc(input logic [COORD_W-1:0] v);
      logic [COORD_W:0] t;
      t = {v[COORD_W-1], v} + {17'd0, {8{v[COORD_W-1]}}};
      return t[23:8];
   endfunction

   // Coordinate format to accumulator format.
   function automatic logic [ACC_W-1:0] to_fine(input logic [COORD_W-1:0] v);
      return {{8{v[COORD_W-1]}}, v, 8'd0};
   endfunction

   function automatic logic [DIVD_W-1:0] mag33(input logic [DIVD_W-1:0] v);
      return v[DIVD_W-1] ? (~v + 33'd1) : v;
   endfunction

endpackage

/* rtl/core/dda_line_rasterizer_interp_core.sv */
`timescale 1ns / 1ps
// A step item gives its result in the cycle after it is accepted; step items
// are taken one per cycle while the result side keeps up.
// A start item for a line that is not a point runs five divisions plus a write each on the shared
// adder, and then a shift-add advance of the accumulators when the major start is negative.
// Reset is synchronous and active high; it clears the line and restores screen 1024 x 768.
// ----------------------------------------------------------------------------
// dda_line_rasterizer_interp_core
// DDA line rasterizer with depth and colour interpolation; the start setup runs on one shared adder.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_interp_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // start_x, start_y, start_depth, start_rgb, end_x, end_y, end_depth, end_rgb
   input  logic [dlri_pkg::REQ_DATA_W-1:0]     req_tdata,
   // opcode
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // pixel_x, pixel_y, pixel_depth, pixel_rgb
   output logic [dlri_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // has_pixel
   output logic                                rsp_tuser,
   // is_last
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_index,
   input  logic [dlri_pkg::SCR_W-1:0]          csr_data
);
   import dlri_pkg::*;

   state_type state_ff;
   logic [SCR_W-1:0] width_ff, height_ff;
   logic line_active_ff, point_ff, x_major_ff, start_neg_ff;
   logic [POS_W-1:0] pos_ff, end_ff, nstep_ff;
   logic [ACC_W-1:0] acc_ff [NUM_ACC];
   logic [ACC_W-1:0] delta_ff [NUM_ACC];
   logic [DIVD_W-1:0] divd_ff [NUM_ACC];
   logic [EXT_W-1:0] ext_ff;
   logic [IDX_W-1:0] k_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [MUL_CNT_W-1:0] bit_ff;
   logic [15:0] rem_ff;
   logic [DIVD_W-1:0] quo_ff;
   logic rsp_valid_ff, rsp_user_ff, rsp_last_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic req_acc, step_acc, start_acc;
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_acc    = req_tvalid && req_tready;
   assign step_acc   = req_acc && (req_tuser == OP_STEP);
   assign start_acc  = req_acc && (req_tuser == OP_START);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ---------------- start item setup ----------------
   logic [COORD_W-1:0] x1, y1, z1, c1, x2, y2, z2, c2;
   assign x1 = req_tdata[23:0];
   assign y1 = req_tdata[47:24];
   assign z1 = req_tdata[71:48];
   assign c1 = req_tdata[95:72];
   assign x2 = req_tdata[119:96];
   assign y2 = req_tdata[143:120];
   assign z2 = req_tdata[167:144];
   assign c2 = req_tdata[191:168];

   logic [24:0] dx, dy, adx, ady;
   logic [EXT_W-1:0] w, h;
   logic x_maj, swap, is_point;
   logic [COORD_W-1:0] ma1, ma2, mi1, mi2, ma_lo, ma_hi, mi_lo, mi_hi, z_lo, z_hi, c_lo, c_hi;
   logic [POS_W-1:0] st16, en16, en_clamp;
   logic [SCR_W-1:0] dim_raw, dim;
   logic [24:0] dmi, dz;
   logic [DIVD_W-1:0] divd_in [NUM_ACC];
   logic [8:0] dc [3];
   logic [8:0] csum [3];
   logic [COORD_W-1:0] zmin;

   always_comb begin
      dx  = {x2[23], x2} - {x1[23], x1};
      dy  = {y2[23], y2} - {y1[23], y1};
      adx = dx[24] ? (~dx + 25'd1) : dx;
      ady = dy[24] ? (~dy + 25'd1) : dy;
      w   = adx[23:8];
      h   = ady[23:8];
      is_point = (w == '0) && (h == '0);
      x_maj = (w >= h);
      ma1 = x_maj ? x1 : y1;
      ma2 = x_maj ? x2 : y2;
      mi1 = x_maj ? y1 : x1;
      mi2 = x_maj ? y2 : x2;
      swap  = !($signed(ma1) < $signed(ma2));
      ma_lo = swap ? ma2 : ma1;
      ma_hi = swap ? ma1 : ma2;
      mi_lo = swap ? mi2 : mi1;
      mi_hi = swap ? mi1 : mi2;
      z_lo  = swap ? z2 : z1;
      z_hi  = swap ? z1 : z2;
      c_lo  = swap ? c2 : c1;
      c_hi  = swap ? c1 : c2;
      st16  = coord_trunc(ma_lo);
      en16  = coord_trunc(ma_hi);
      dim_raw = x_maj ? width_ff : height_ff;
      dim   = (dim_raw > MAX_DIM) ? MAX_DIM : dim_raw;
      if ($signed({en16[15], en16}) >= $signed({4'd0, dim})) begin
         en_clamp = 16'({3'd0, dim} - 16'd1);
      end else begin
         en_clamp = en16;
      end
      dmi = {mi_hi[23], mi_hi} - {mi_lo[23], mi_lo};
      dz  = {z_hi[23], z_hi} - {z_lo[23], z_lo};
      divd_in[ACC_MINOR] = {dmi, 8'd0};
      divd_in[ACC_DEPTH] = {dz, 8'd0};
      for (int k = 0; k < 3; k++) begin
         dc[k]   = {1'b0, c_hi[23-8*k -: 8]} - {1'b0, c_lo[23-8*k -: 8]};
         csum[k] = {1'b0, c1[23-8*k -: 8]} + {1'b0, c2[23-8*k -: 8]};
         divd_in[2+k] = {{8{dc[k][8]}}, dc[k], 16'd0};
      end
      zmin = ($signed(z1) < $signed(z2)) ? z1 : z2;
   end

   // ---------------- step item output ----------------
   logic [ACC_W-1:0] tmin, tdep;
   logic [23:0] qmin;
   logic [31:0] qdep;
   logic [POS_W-1:0] minor_o;
   logic [23:0] depth_o, rgb_o, cv;
   logic has_o, last_o;
   logic [RSP_DATA_W-1:0] data_o;

   always_comb begin
      tmin = acc_ff[ACC_MINOR] + {24'd0, {16{acc_ff[ACC_MINOR][ACC_W-1]}}};
      qmin = tmin[39:16];
      if (qmin[23:15] == '0 || qmin[23:15] == '1) begin
         minor_o = qmin[15:0];
      end else begin
         minor_o = qmin[23] ? 16'h8000 : 16'h7fff;
      end
      tdep = acc_ff[ACC_DEPTH] + {32'd0, {8{acc_ff[ACC_DEPTH][ACC_W-1]}}};
      qdep = tdep[39:8];
      if (qdep[31:23] == '0 || qdep[31:23] == '1) begin
         depth_o = qdep[23:0];
      end else begin
         depth_o = qdep[31] ? 24'h800000 : 24'h7fffff;
      end
      rgb_o = '0;
      for (int k = 0; k < 3; k++) begin
         cv = acc_ff[2+k][39:16];
         if (acc_ff[2+k][ACC_W-1]) begin
            rgb_o[23-8*k -: 8] = 8'd0;
         end else if (cv[23:8] != '0) begin
            rgb_o[23-8*k -: 8] = 8'hff;
         end else begin
            rgb_o[23-8*k -: 8] = cv[7:0];
         end
      end
      has_o  = point_ff || acc_ff[ACC_DEPTH][ACC_W-1] || (acc_ff[ACC_DEPTH] == '0);
      last_o = point_ff || ($signed(pos_ff) >= $signed(end_ff));
      if (x_major_ff) begin
         data_o = {rgb_o, depth_o, minor_o, pos_ff};
      end else begin
         data_o = {rgb_o, depth_o, pos_ff, minor_o};
      end
   end

   // ---------------- shared adder ----------------
   logic [16:0] rem_sh;
   logic [ACC_W-1:0] add_a, add_b, add_sum, q40;
   logic div_ge;

   always_comb begin
      rem_sh = {rem_ff, quo_ff[DIVD_W-1]};
      if (state_ff == ST_MUL) begin
         add_a = acc_ff[k_ff];
         add_b = delta_ff[k_ff] << bit_ff;
      end else begin
         add_a = {23'd0, rem_sh};
         add_b = ~{24'd0, ext_ff} + 40'd1;
      end
      add_sum = add_a + add_b;
      div_ge  = !add_sum[ACC_W-1];
      q40 = {7'd0, quo_ff};
      if (divd_ff[k_ff][DIVD_W-1]) begin
         q40 = ~q40 + 40'd1;
      end
   end

   // ---------------- control and datapath ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         width_ff       <= WIDTH_RESET;
         height_ff      <= HEIGHT_RESET;
         line_active_ff <= 1'b0;
         point_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         k_ff           <= '0;
         cnt_ff         <= '0;
         bit_ff         <= '0;
      end else begin
         if (csr_valid) begin
            if (csr_index == REG_WIDTH) begin
               width_ff <= csr_data;
            end else begin
               height_ff <= csr_data;
            end
         end
         if (step_acc) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (step_acc) begin
                  if (!line_active_ff) begin
                     rsp_data_ff <= '0;
                     rsp_user_ff <= 1'b0;
                     rsp_last_ff <= 1'b1;
                  end else begin
                     rsp_data_ff <= data_o;
                     rsp_user_ff <= has_o;
                     rsp_last_ff <= last_o;
                     if (last_o) begin
                        line_active_ff <= 1'b0;
                        point_ff       <= 1'b0;
                     end else begin
                        pos_ff <= pos_ff + 16'd1;
                        for (int k = 0; k < NUM_ACC; k++) begin
                           acc_ff[k] <= acc_ff[k] + delta_ff[k];
                        end
                     end
                  end
               end else if (start_acc) begin
                  if (is_point) begin
                     line_active_ff <= 1'b1;
                     point_ff       <= 1'b1;
                     x_major_ff     <= 1'b1;
                     pos_ff         <= coord_trunc(x1);
                     end_ff         <= coord_trunc(x1);
                     acc_ff[ACC_MINOR] <= to_fine(y1);
                     acc_ff[ACC_DEPTH] <= to_fine(zmin);
                     for (int k = 0; k < 3; k++) begin
                        acc_ff[2+k] <= {16'd0, csum[k], 15'd0};
                     end
                  end else begin
                     line_active_ff <= 1'b0;
                     point_ff       <= 1'b0;
                     x_major_ff     <= x_maj;
                     start_neg_ff   <= st16[POS_W-1];
                     nstep_ff       <= ~st16 + 16'd1;
                     pos_ff         <= st16[POS_W-1] ? '0 : st16;
                     end_ff         <= en_clamp;
                     ext_ff         <= x_maj ? w : h;
                     acc_ff[ACC_MINOR] <= to_fine(mi_lo);
                     acc_ff[ACC_DEPTH] <= to_fine(z_lo);
                     for (int k = 0; k < 3; k++) begin
                        acc_ff[2+k] <= {16'd0, c_lo[23-8*k -: 8], 16'd0};
                     end
                     for (int k = 0; k < NUM_ACC; k++) begin
                        divd_ff[k] <= divd_in[k];
                     end
                     k_ff     <= ACC_MINOR;
                     cnt_ff   <= '0;
                     rem_ff   <= '0;
                     quo_ff   <= mag33(divd_in[ACC_MINOR]);
                     state_ff <= ST_DIV;
                  end
               end
            end
            ST_DIV: begin
               // One restoring quotient bit per cycle.
               rem_ff <= div_ge ? add_sum[15:0] : rem_sh[15:0];
               quo_ff <= {quo_ff[DIVD_W-2:0], div_ge};
               if (cnt_ff == DIV_LAST_CNT) begin
                  state_ff <= ST_DIVWR;
               end else begin
                  cnt_ff <= cnt_ff + 6'd1;
               end
            end
            ST_DIVWR: begin
               delta_ff[k_ff] <= q40;
               cnt_ff <= '0;
               rem_ff <= '0;
               if (k_ff == LAST_ACC) begin
                  k_ff   <= '0;
                  bit_ff <= '0;
                  if (start_neg_ff) begin
                     state_ff <= ST_MUL;
                  end else begin
                     line_active_ff <= ($signed(pos_ff) <= $signed(end_ff));
                     state_ff <= ST_IDLE;
                  end
               end else begin
                  k_ff     <= k_ff + 3'd1;
                  quo_ff   <= mag33(divd_ff[k_ff + 3'd1]);
                  state_ff <= ST_DIV;
               end
            end
            ST_MUL: begin
               // Advance the accumulators by the skipped steps, one bit of the count a cycle.
               if (nstep_ff[bit_ff]) begin
                  acc_ff[k_ff] <= add_sum;
               end
               bit_ff <= bit_ff + 4'd1;
               if (bit_ff == '1) begin
                  if (k_ff == LAST_ACC) begin
                     line_active_ff <= ($signed(pos_ff) <= $signed(end_ff));
                     state_ff <= ST_IDLE;
                  end else begin
                     k_ff <= k_ff + 3'd1;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_no_line_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !line_active_ff)
      else $error("line active during setup");
   a_point_needs_line: assert property (@(posedge clock) disable iff (reset)
      point_ff |-> line_active_ff)
      else $error("point case without active line");
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cnt_ff <= DIV_LAST_CNT))
      else $error("divider count overrun");
   a_idle_step_last: assert property (@(posedge clock) disable iff (reset)
      (step_acc && !line_active_ff) |=> (rsp_valid_ff && rsp_last_ff && !rsp_user_ff))
      else $error("step without line must be last");
`endif

endmodule

/* bench/dda_line_rasterizer_interp_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDA line rasterizer core testbench
// A behavioral pixel predictor runs alongside the core. Directed lines cover
// the corner cases: no active line, point lines, reversed endpoints,
// negative starts, screen clamps and empty lines. Random lines with random
// stalls on both stream sides and screen size changes follow.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_interp_core_tb;
   import dlri_pkg::*;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic [23:0] z;
      logic [23:0] rgb;
      logic        hit;
      logic        last;
   } pixel_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tuser = OP_STEP;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_index = REG_WIDTH;
   logic [SCR_W-1:0] csr_data = '0;

   dda_line_rasterizer_interp_core u_top (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predictor state.
   longint scr_w = 1024, scr_h = 768;
   bit     ln_active, ln_xmajor, ln_point;
   longint ln_pos, ln_end, acc_minor, acc_depth;
   longint acc_col[3];
   longint delta[5];

   pixel_t expected_pixels[$];
   int     errors = 0;
   int     items_sent = 0;
   bit     stalls_on = 1'b1;
   int     quiet_cycles = 0;

   function automatic longint sx24(logic [23:0] v);
      longint r;
      r = {{40{v[23]}}, v};
      return r;
   endfunction

   function automatic longint wrap40(longint v);
      longint r;
      r = {{24{v[39]}}, v[39:0]};
      return r;
   endfunction

   function automatic longint trunc_sh(longint v, int n);
      return (v < 0) ? -((-v) >>> n) : (v >>> n);
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic longint chan(logic [23:0] c, int k);
      return longint'((c >> (16 - 8 * k)) & 24'hFF);
   endfunction

   function automatic logic [REQ_DATA_W-1:0] endpoints(longint x1, longint y1, longint z1,
         logic [23:0] c1, longint x2, longint y2, longint z2, logic [23:0] c2);
      return {c2, z2[23:0], y2[23:0], x2[23:0], c1, z1[23:0], y1[23:0], x1[23:0]};
   endfunction

   function automatic void latch_line(logic [REQ_DATA_W-1:0] d);
      longint x1, y1, z1, x2, y2, z2, w, h, ma1, ma2, mi1, mi2, ext, first, stop, dim, t, n;
      logic [23:0] c1, c2, tc;
      x1 = sx24(d[23:0]);    y1 = sx24(d[47:24]);   z1 = sx24(d[71:48]);
      c1 = d[95:72];
      x2 = sx24(d[119:96]);  y2 = sx24(d[143:120]); z2 = sx24(d[167:144]);
      c2 = d[191:168];
      w = ((x2 > x1) ? x2 - x1 : x1 - x2) >>> 8;
      h = ((y2 > y1) ? y2 - y1 : y1 - y2) >>> 8;
      ln_active = 1'b0;
      ln_point = 1'b0;
      if (w == 0 && h == 0) begin
         ln_point = 1'b1;
         ln_xmajor = 1'b1;
         ln_pos = trunc_sh(x1, 8);
         ln_end = ln_pos;
         acc_minor = wrap40(y1 * 256);
         acc_depth = wrap40(((z1 < z2) ? z1 : z2) * 256);
         for (int k = 0; k < 3; k++)
            acc_col[k] = ((chan(c1, k) + chan(c2, k)) * 65536) / 2;
         ln_active = 1'b1;
         return;
      end
      ln_xmajor = (w >= h);
      if (ln_xmajor) begin
         ma1 = x1; ma2 = x2; mi1 = y1; mi2 = y2; ext = w;
         dim = (scr_w > 4096) ? 4096 : scr_w;
      end else begin
         ma1 = y1; ma2 = y2; mi1 = x1; mi2 = x2; ext = h;
         dim = (scr_h > 4096) ? 4096 : scr_h;
      end
      if (!(ma1 < ma2)) begin
         t = ma1; ma1 = ma2; ma2 = t;
         t = mi1; mi1 = mi2; mi2 = t;
         t = z1; z1 = z2; z2 = t;
         tc = c1; c1 = c2; c2 = tc;
      end
      first = trunc_sh(ma1, 8);
      stop = trunc_sh(ma2, 8);
      acc_minor = wrap40(mi1 * 256);
      acc_depth = wrap40(z1 * 256);
      delta[ACC_MINOR] = wrap40((mi2 * 256 - mi1 * 256) / ext);
      delta[ACC_DEPTH] = wrap40((z2 * 256 - z1 * 256) / ext);
      for (int k = 0; k < 3; k++) begin
         acc_col[k] = chan(c1, k) * 65536;
         delta[ACC_RED + k] = wrap40(((chan(c2, k) - chan(c1, k)) * 65536) / ext);
      end
      // A negative start is advanced to column or row zero in one jump.
      if (first < 0) begin
         n = -first;
         acc_minor = wrap40(acc_minor + n * delta[ACC_MINOR]);
         acc_depth = wrap40(acc_depth + n * delta[ACC_DEPTH]);
         for (int k = 0; k < 3; k++)
            acc_col[k] = wrap40(acc_col[k] + n * delta[ACC_RED + k]);
         first = 0;
      end
      if (stop >= dim) stop = dim - 1;
      ln_pos = first;
      ln_end = stop;
      ln_active = (first <= stop);
   endfunction

   function automatic pixel_t next_pixel();
      pixel_t p;
      longint minor, depth, v;
      p = '0;
      p.last = 1'b1;
      if (!ln_active) return p;
      minor = clip(trunc_sh(acc_minor, 16), -32768, 32767);
      depth = clip(trunc_sh(acc_depth, 8), -8388608, 8388607);
      for (int k = 0; k < 3; k++) begin
         v = (acc_col[k] < 0) ? 0 : (acc_col[k] >>> 16);
         if (v > 255) v = 255;
         p.rgb[16 - 8 * k +: 8] = v[7:0];
      end
      p.x = ln_xmajor ? ln_pos[15:0] : minor[15:0];
      p.y = ln_xmajor ? minor[15:0] : ln_pos[15:0];
      p.z = depth[23:0];
      p.hit = ln_point || acc_depth <= 0;
      if (ln_point || ln_pos >= ln_end) begin
         ln_active = 1'b0;
         ln_point = 1'b0;
      end else begin
         p.last = 1'b0;
         ln_pos++;
         acc_minor = wrap40(acc_minor + delta[ACC_MINOR]);
         acc_depth = wrap40(acc_depth + delta[ACC_DEPTH]);
         for (int k = 0; k < 3; k++)
            acc_col[k] = wrap40(acc_col[k] + delta[ACC_RED + k]);
      end
      return p;
   endfunction

   function automatic longint pixels_left();
      if (!ln_active) return 0;
      return ln_point ? 1 : ln_end - ln_pos + 1;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_item(logic op, logic [REQ_DATA_W-1:0] d);
      if (stalls_on && $urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 4)) @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser = op;
      req_tdata = d;
      do @(posedge clock); while (!req_tready);
      if (op == OP_START) latch_line(d);
      else expected_pixels.push_back(next_pixel());
      items_sent++;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic draw_line(logic [REQ_DATA_W-1:0] d, int steps);
      send_item(OP_START, d);
      repeat (steps) send_item(OP_STEP, REQ_DATA_W'($urandom));
   endtask

   // The core may still be busy with a start item when the queue drains.
   task automatic write_screen(logic idx, logic [SCR_W-1:0] val);
      wait (expected_pixels.size() == 0);
      repeat (300) @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = val;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_WIDTH) scr_w = val;
      else scr_h = val;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic test_no_line();
      send_item(OP_STEP, '1);
      send_item(OP_STEP, '0);
   endtask

   task automatic test_basic_lines();
      // x-major, then y-major with reversed endpoints replacing it mid-line.
      draw_line(endpoints(640, 768, -512, 24'h102030, 1984, 1152, 2048, 24'hF0E0D0), 4);
      draw_line(endpoints(2560, 5120, 300, 24'hFFFFFF, 2304, 3584, -300, 24'h000000), 8);
      // Point line: colours averaged, smaller depth.
      draw_line(endpoints(-700, 900, 5000, 24'hFF01FF, -650, 1000, 4000, 24'h01FF00), 2);
   endtask

   task automatic test_edges();
      // Negative major start gets advanced to zero.
      draw_line(endpoints(-1000, 50, -100, 24'h00FF00, 600, 800, 100, 24'hFF0000), 4);
      // Extreme coordinates: huge negative start and a clamped end.
      draw_line(endpoints(-8388608, 8388607, -8388608, 24'h000000,
                          8388607, -8388608, 8388607, 24'hFFFFFF), 2);
      // Start beyond the screen: nothing becomes active.
      draw_line(endpoints(2000 * 256, 0, 0, 24'h123456, 3000 * 256, 10, 0, 24'h654321), 1);
   endtask

   function automatic longint rand_coord(bit wide);
      if (wide) return sx24(24'($urandom));
      return longint'($urandom_range(0, 24 * 256)) - 8 * 256;
   endfunction

   task automatic test_random_lines();
      logic [REQ_DATA_W-1:0] d;
      longint x1, y1, n;
      int pick;
      bit wide;
      logic [SCR_W-1:0] dims[8];
      dims = '{13'd0, 13'd1, 13'd2, 13'd17, 13'd1024, 13'd4096, 13'd4097, 13'd8191};
      while (items_sent < 1100) begin
         if (items_sent > 1000) stalls_on = 1'b0;
         if ($urandom_range(0, 40) == 0)
            write_screen(1'($urandom_range(0, 1)),
                         ($urandom_range(0, 1) == 1) ? dims[$urandom_range(0, 7)]
                                                      : SCR_W'($urandom_range(0, 8191)));
         pick = $urandom_range(0, 19);
         wide = (pick == 0);
         x1 = rand_coord(wide);
         y1 = rand_coord(wide);
         if (pick == 1)
            d = endpoints(x1, y1, sx24(24'($urandom)), 24'($urandom),
                          x1 + $urandom_range(0, 255), y1 + $urandom_range(0, 255),
                          sx24(24'($urandom)), 24'($urandom));
         else
            d = endpoints(x1, y1, longint'($urandom_range(0, 2048)) - 1024, 24'($urandom),
                          rand_coord(wide), rand_coord(wide),
                          longint'($urandom_range(0, 2048)) - 1024, 24'($urandom));
         if (pick == 2) d = REQ_DATA_W'($urandom);
         send_item(OP_START, d);
         n = pixels_left() + $urandom_range(0, 2);
         if (n > 40 || $urandom_range(0, 9) == 0) n = $urandom_range(0, 40);
         repeat (n) send_item(OP_STEP, REQ_DATA_W'($urandom));
      end
   endtask

   task automatic check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         errors++;
         $display("%0t %s expected %h actual %h", $time, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      pixel_t exp_p;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pixels.size() == 0) begin
            errors++;
            $display("%0t unexpected pixel, expected none, actual %h", $time, rsp_tdata);
         end else begin
            exp_p = expected_pixels.pop_front();
            check_field("pixel_x", exp_p.x, rsp_tdata[15:0]);
            check_field("pixel_y", exp_p.y, rsp_tdata[31:16]);
            check_field("pixel_depth", exp_p.z, rsp_tdata[55:32]);
            check_field("pixel_rgb", exp_p.rgb, rsp_tdata[79:56]);
            check_field("has_pixel", exp_p.hit, rsp_tuser);
            check_field("is_last", exp_p.last, rsp_tlast);
         end
      end
   end

   // Result-side back pressure in short bursts.
   int hold_left = 0;
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready = 1'b0;
      end else if (stalls_on && $urandom_range(0, 4) == 0) begin
         hold_left = $urandom_range(0, 3);
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == 5000) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_no_line();
      test_basic_lines();
      test_edges();
      write_screen(REG_WIDTH, 13'd1);
      write_screen(REG_HEIGHT, 13'd8191);
      draw_line(endpoints(-300, 100, 0, 24'hABCDEF, 700, 9000, -50, 24'h00FF7F), 3);
      write_screen(REG_HEIGHT, 13'd0);
      draw_line(endpoints(100, 100, 0, 24'h0, 200, 2000, 0, 24'h0), 1);
      write_screen(REG_WIDTH, 13'd4096);
      write_screen(REG_HEIGHT, 13'd1);
      test_random_lines();
      wait (expected_pixels.size() == 0);
      repeat (200) @(posedge clock);
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
